// ===== sv/supply_voltage_window_average_assert.svh =====
// Assertion macros for the supply voltage window average port checker.
// No dependencies; included by the checker file.
`ifndef SUPPLY_VOLTAGE_WINDOW_AVERAGE_ASSERT_SVH
`define SUPPLY_VOLTAGE_WINDOW_AVERAGE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SVWA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svwa assertion failed");

// Next-cycle implication, disabled during reset.
`define SVWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svwa assertion failed");

`endif

// ===== sv/svwa_pkg.sv =====
// Package for the supply voltage window average block: widths, CSR map,
// and the command/status structs between controller and datapath.
// No dependencies.
package svwa_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int REF_W      = 11;
   localparam int MV_W       = 21;
   localparam int SUM_W      = 28;
   localparam int DIVD_W     = 28;
   localparam int DIVR_W     = 10;
   localparam int ITER_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ITER_W-1:0] EST_ITERS = 5'd21;
   localparam logic [ITER_W-1:0] AVG_ITERS = 5'd28;

   localparam logic [REF_W-1:0] REF_RESET = 11'd1100;
   localparam logic [MV_W-1:0]  MV_MAX    = 21'd2094081;

   // register index, taken from paddr[2]
   localparam logic REG_REFERENCE_MV = 1'b0;

   typedef struct packed {
      logic accept;
      logic retire;
      logic update;
      logic load_out;
   } svwa_cmd_type;

   typedef struct packed {
      logic div_busy;
   } svwa_status_type;

endpackage

// ===== sv/svwa_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the estimate and
// the average. Depends on svwa_pkg.
module svwa_div
   import svwa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVR_W-1:0] divisor,
   input  logic [ITER_W-1:0] iters,
   output logic              busy,
   output logic [DIVD_W-1:0] quotient
);

   logic [ITER_W-1:0] cnt_ff;
   logic [DIVD_W-1:0] dvd_ff;
   logic [DIVR_W-1:0] dvs_ff;
   logic [DIVR_W-1:0] rem_ff;
   logic [DIVD_W-1:0] quo_ff;

   logic [DIVR_W:0]   rem_shift;
   logic [DIVR_W+1:0] diff;
   logic              ge;
   logic [DIVR_W-1:0] rem_in;

   assign rem_shift = {rem_ff, dvd_ff[DIVD_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign ge        = ~diff[DIVR_W+1];
   // remainder stays below the divisor, so it fits DIVR_W bits either way
   assign rem_in    = ge ? diff[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= iters;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy) begin
         dvd_ff <= {dvd_ff[DIVD_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIVD_W-2:0], ge};
      end
   end

endmodule

// ===== sv/svwa_dp.sv =====
// Datapath: estimate ring memory, running sum, fill count, write index,
// shared divider and result registers. Depends on svwa_pkg and svwa_div.
module svwa_dp
   import svwa_pkg::*;
#(
   parameter int WINDOW = 100
)
(
   input  logic                clock,
   input  logic                reset,
   input  svwa_cmd_type        cmd,
   output svwa_status_type     status,
   input  logic [REF_W-1:0]    reference_mv,
   input  logic [SAMPLE_W-1:0] adc_sample,
   output logic [MV_W-1:0]     average_mv,
   output logic [MV_W-1:0]     latest_mv,
   output logic                zero_reading
);

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(WINDOW);

   logic [MV_W-1:0]   ring [WINDOW];
   logic [MV_W-1:0]   old_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              zero_ff;
   logic [MV_W-1:0]   est_ff;
   logic [MV_W-1:0]   avg_out_ff;
   logic [MV_W-1:0]   latest_out_ff;
   logic              zero_out_ff;

   logic              full;
   logic [MV_W-1:0]   product;
   logic [DIVR_W-1:0] est_divisor;
   logic [MV_W-1:0]   est_new;
   logic [SUM_W-1:0]  sum_in;
   logic [FILL_W-1:0] fill_in;
   logic              div_start;
   logic [DIVD_W-1:0] div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic [ITER_W-1:0] div_iters;
   logic              div_busy;
   logic [DIVD_W-1:0] div_quotient;

   assign full        = (fill_ff == FULL_CNT);
   // reference * 1023 as a shift and subtract
   assign product     = {reference_mv, 10'b0} - {10'b0, reference_mv};
   assign est_divisor = (adc_sample == '0) ? DIVR_W'(1) : adc_sample;
   assign est_new     = div_quotient[MV_W-1:0];
   assign sum_in      = sum_ff + {{(SUM_W-MV_W){1'b0}}, est_new};
   assign fill_in     = full ? fill_ff : fill_ff + 1'b1;

   always_comb begin
      div_start = cmd.accept | cmd.update;
      if (cmd.update) begin
         div_dividend = sum_in;
         div_divisor  = {{(DIVR_W-FILL_W){1'b0}}, fill_in};
         div_iters    = AVG_ITERS;
      end else begin
         // left-align the 21-bit product so 21 steps finish it
         div_dividend = {product, {(DIVD_W-MV_W){1'b0}}};
         div_divisor  = est_divisor;
         div_iters    = EST_ITERS;
      end
   end

   svwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .iters    (div_iters),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign status.div_busy = div_busy;

   // ring: read the oldest entry at accept, overwrite it at update
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         old_ff <= ring[idx_ff];
      end
      if (cmd.update) begin
         ring[idx_ff] <= est_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fill_ff <= '0;
         idx_ff  <= '0;
      end else if (cmd.retire) begin
         if (full) begin
            sum_ff <= sum_ff - {{(SUM_W-MV_W){1'b0}}, old_ff};
         end
      end else if (cmd.update) begin
         sum_ff  <= sum_in;
         fill_ff <= fill_in;
         idx_ff  <= (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         zero_ff <= (adc_sample == '0);
      end
      if (cmd.update) begin
         est_ff <= est_new;
      end
      if (cmd.load_out) begin
         avg_out_ff    <= div_quotient[MV_W-1:0];
         latest_out_ff <= est_ff;
         zero_out_ff   <= zero_ff;
      end
   end

   assign average_mv   = avg_out_ff;
   assign latest_mv    = latest_out_ff;
   assign zero_reading = zero_out_ff;

endmodule

// ===== sv/svwa_ctrl.sv =====
// Controller state machine: sequences accept, sum retire, the two
// divisions and the result transfer. Depends on svwa_pkg.
module svwa_ctrl
   import svwa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  svwa_status_type status,
   output svwa_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_RETIRE   = 4'b0010,
      ST_EST_WAIT = 4'b0100,
      ST_AVG_WAIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            cmd.retire = 1'b1;
            state_in   = ST_EST_WAIT;
         end
         ST_EST_WAIT: begin
            if (!status.div_busy) begin
               cmd.update = 1'b1;
               state_in   = ST_AVG_WAIT;
            end
         end
         ST_AVG_WAIT: begin
            // hold the quotient until the output register is free
            if (!status.div_busy && out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/supply_voltage_window_average.sv =====
// Supply voltage window average, top level.
// Request channel: req_valid/req_stall carry one 10-bit converter reading of
//   the internal reference (req_adc_sample); a transfer happens when valid is
//   high and stall is low.
// Response channel: rsp_valid/rsp_stall carry the truncated mean of the last
//   WINDOW supply estimates, this sample's estimate (reference_mv*1023/reading)
//   and a flag for a zero reading, which is divided as a reading of one.
// CSR port (APB style): register 0 at byte address 0 is reference_mv, 11 bits,
//   reset 1100. Write it only while the block is idle.
// Samples are taken one at a time, paced by the single restoring divider: 21
//   steps for the estimate and 28 for the average, plus the accept, the sum
//   update that launches the average, and the handoff to the output register.
// The result sits in an output register; while the receiver stalls it holds,
//   and the next sample is accepted meanwhile. A finished average waits in
//   the divider until the output register frees up.
// Reset (synchronous) empties the window: sum, fill count and write index go
//   to zero, reference_mv to 1100, and no response is pending.
// Depends on svwa_pkg, svwa_ctrl, svwa_dp and svwa_div.
module supply_voltage_window_average
   import svwa_pkg::*;
#(
   parameter int WINDOW = 100
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_adc_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MV_W-1:0]       rsp_average_mv,
   output logic [MV_W-1:0]       rsp_latest_mv,
   output logic                  rsp_zero_reading,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [REF_W-1:0] reference_mv_ff;
   logic             csr_wr;
   svwa_cmd_type     cmd;
   svwa_status_type  status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == REG_REFERENCE_MV);

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_mv_ff <= REF_RESET;
      end else if (csr_wr) begin
         reference_mv_ff <= csr_pwdata[REF_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_REFERENCE_MV)
                       ? {{(CSR_DATA_W-REF_W){1'b0}}, reference_mv_ff} : '0;

   svwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   svwa_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .reference_mv (reference_mv_ff),
      .adc_sample   (req_adc_sample),
      .average_mv   (rsp_average_mv),
      .latest_mv    (rsp_latest_mv),
      .zero_reading (rsp_zero_reading)
   );

endmodule

// ===== sv/svwa_checker.sv =====
// Port-level checker for the supply voltage window average block, bound to
// the top level. Depends on svwa_pkg and the assertion macro header.
`include "supply_voltage_window_average_assert.svh"

module svwa_port_checker
   import svwa_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input logic [MV_W-1:0] rsp_average_mv,
   input logic [MV_W-1:0] rsp_latest_mv,
   input logic            rsp_zero_reading
);

   logic              rsp_held;
   logic [2*MV_W:0]   rsp_data;
   logic              rsp_in_range;

   assign rsp_held     = rsp_valid && rsp_stall;
   assign rsp_data     = {rsp_average_mv, rsp_latest_mv, rsp_zero_reading};
   assign rsp_in_range = (rsp_average_mv <= MV_MAX) && (rsp_latest_mv <= MV_MAX);

   // one sample in flight: a transfer closes the request side at once
   `SVWA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a stalled response holds its payload
   `SVWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // a fresh response only comes out of a busy cycle
   `SVWA_ASSERT_IMPLY(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // neither the mean nor the latest estimate exceeds the largest possible estimate
   `SVWA_ASSERT_IMPLY(a_avg_range, clock, reset, rsp_valid, rsp_in_range)

endmodule

bind supply_voltage_window_average svwa_port_checker u_svwa_port_checker (.*);

// ===== tb/svwa_checker.sv =====
`timescale 1ns / 1ps
// Checker for the supply voltage window average block: watches the CSR port and
// both channels, predicts each response and compares it. Depends on svwa_pkg.
module svwa_checker
   import svwa_pkg::*;
#(
   parameter int WINDOW = 100
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_adc_sample,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [MV_W-1:0]       rsp_average_mv,
   input  logic [MV_W-1:0]       rsp_latest_mv,
   input  logic                  rsp_zero_reading,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count = 0,
   output int                    pending_count = 0,
   output int                    compared_count = 0
);

   localparam logic [31:0] FULL_SCALE = 32'd1023;

   typedef struct packed {
      logic [MV_W-1:0] average_mv;
      logic [MV_W-1:0] latest_mv;
      logic            zero_reading;
   } supply_result_type;

   supply_result_type expected_supply[$];
   logic [MV_W-1:0] estimate_ring [WINDOW];
   logic [SUM_W-1:0] window_sum = '0;
   int unsigned     window_fill = 0;
   int unsigned     slot_index = 0;
   logic [REF_W-1:0] reference_mv = REF_RESET;
   int              mismatches = 0;
   int              compared = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // Fold one reading into the window and queue the response it must produce.
   task automatic absorb_reading(input logic [SAMPLE_W-1:0] reading);
      logic [31:0]       divisor;
      logic [31:0]       estimate;
      supply_result_type want;
      divisor  = (reading == '0) ? 32'd1 : 32'(reading);
      estimate = (32'(reference_mv) * FULL_SCALE) / divisor;
      if (window_fill >= WINDOW)
         window_sum = window_sum - SUM_W'(estimate_ring[slot_index]);
      else
         window_fill++;
      estimate_ring[slot_index] = estimate[MV_W-1:0];
      window_sum = window_sum + SUM_W'(estimate[MV_W-1:0]);
      slot_index = (slot_index + 1 >= WINDOW) ? 0 : slot_index + 1;
      want.average_mv   = MV_W'(32'(window_sum) / window_fill);
      want.latest_mv    = estimate[MV_W-1:0];
      want.zero_reading = (reading == '0);
      expected_supply.push_back(want);
   endtask

   task automatic compare_response();
      supply_result_type want;
      if (expected_supply.size() == 0) begin
         report_mismatch($sformatf("response with no sample outstanding (average %0d latest %0d)",
                                   rsp_average_mv, rsp_latest_mv));
      end else begin
         want = expected_supply.pop_front();
         compared++;
         if (rsp_average_mv !== want.average_mv)
            report_mismatch($sformatf("average_mv got %0d expected %0d",
                                      rsp_average_mv, want.average_mv));
         if (rsp_latest_mv !== want.latest_mv)
            report_mismatch($sformatf("latest_mv got %0d expected %0d",
                                      rsp_latest_mv, want.latest_mv));
         if (rsp_zero_reading !== want.zero_reading)
            report_mismatch($sformatf("zero_reading got %0b expected %0b",
                                      rsp_zero_reading, want.zero_reading));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reference_mv = REF_RESET;
         window_sum   = '0;
         window_fill  = 0;
         slot_index   = 0;
         expected_supply.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == REG_REFERENCE_MV) begin
            if (csr_pwrite)
               reference_mv = csr_pwdata[REF_W-1:0];
            else if (csr_prdata !== CSR_DATA_W'(reference_mv))
               report_mismatch($sformatf("reference_mv readback got %0d expected %0d",
                                         csr_prdata, reference_mv));
         end
         if (req_valid && !req_stall)
            absorb_reading(req_adc_sample);
         if (rsp_valid && !rsp_stall)
            compare_response();
      end
      fail_count     <= mismatches;
      pending_count  <= expected_supply.size();
      compared_count <= compared;
   end

endmodule

// ===== tb/tb_supply_voltage_window_average.sv =====
`timescale 1ns / 1ps
// Top of the supply voltage window average testbench: clock, reset, stimulus
// and verdict. Depends on svwa_pkg, svwa_checker and the block itself.
module tb_supply_voltage_window_average;
   import svwa_pkg::*;

   localparam int WINDOW       = 100;
   localparam int RANDOM_ITEMS = 1850;
   localparam int PHASES       = 8;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 120;

   localparam logic [CSR_ADDR_W-1:0] ADDR_REFERENCE = {REG_REFERENCE_MV, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE     = {~REG_REFERENCE_MV, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_adc_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [MV_W-1:0]       rsp_average_mv;
   logic [MV_W-1:0]       rsp_latest_mv;
   logic                  rsp_zero_reading;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int  fail_count;
   int  pending_count;
   int  compared_count;
   int  cycle_count = 0;
   int  samples_sent = 0;
   int  zero_samples = 0;
   int  settings_used = 0;
   int  stall_hold = 0;
   logic calm = 1'b0;

   supply_voltage_window_average #(.WINDOW(WINDOW)) dut (.*);

   svwa_checker #(.WINDOW(WINDOW)) u_svwa_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Receiver back-pressure: short random stalls plus an occasional long one.
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm && $urandom_range(99) < 27) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(499) == 0)
            stall_hold <= $urandom_range(10, 70);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 27)
         gap = ($urandom_range(9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= value;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      if (value == '0)
         zero_samples++;
   endtask

   // Let every outstanding response arrive so the block is idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // A setup phase, an access phase held until pready, then the port released.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reference(input logic [REF_W-1:0] mv);
      csr_access(1'b1, ADDR_REFERENCE, CSR_DATA_W'(mv));
      csr_access(1'b0, ADDR_REFERENCE, '0);
      settings_used++;
   endtask

   // Plausible readings around a 3.3 V rail, with edges and full range mixed in.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       pick_sample = '0;
         1:       pick_sample = '1;
         2:       pick_sample = SAMPLE_W'($urandom_range(1, 8));
         3, 4, 5: pick_sample = SAMPLE_W'($urandom_range(300, 400));
         default: pick_sample = SAMPLE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   initial begin
      logic [REF_W-1:0] phase_ref;
      int               per_phase;
      per_phase = RANDOM_ITEMS / PHASES;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset reference first, then the extremes of the register
      csr_access(1'b0, ADDR_REFERENCE, '0);
      send_sample('0);
      send_sample(10'd1);
      send_sample(10'd1023);
      send_sample(10'd512);
      send_sample(10'd2);
      send_sample(10'd341);
      send_sample(10'd1022);
      wait_idle();
      set_reference(11'd2047);
      send_sample('0);
      send_sample(10'd1);
      send_sample(10'd1023);
      send_sample(10'd3);
      wait_idle();
      // write to an unmapped address must leave the reference alone
      csr_access(1'b1, ADDR_SPARE, 32'h0000_0005);
      send_sample(10'd1000);
      wait_idle();
      set_reference(11'd0);
      send_sample('0);
      send_sample(10'd1023);
      send_sample(10'd7);
      wait_idle();
      set_reference(11'd1);
      send_sample('0);
      send_sample(10'd1023);
      send_sample(10'd682);
      send_sample(10'd1);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0, 7:    phase_ref = 11'd1100;
            1:       phase_ref = 11'd2047;
            2:       phase_ref = 11'd0;
            4:       phase_ref = 11'd1;
            6:       phase_ref = 11'd1023;
            default: phase_ref = REF_W'($urandom_range(2, 2046));
         endcase
         wait_idle();
         set_reference(phase_ref);
         calm = (p == 3);
         for (int i = 0; i < per_phase; i++)
            send_sample(pick_sample());
      end
      calm = 1'b0;

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d samples (%0d zero readings) over %0d reference settings.",
               samples_sent, zero_samples, settings_used);
      $display("%0d responses compared, %0d mismatches.", compared_count, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles with %0d responses outstanding.",
               cycle_count, pending_count);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
